[src/asqf_pkg.sv]
`default_nettype none
package asqf_pkg;

  localparam int ADDR_W = 64;
  localparam int LOW_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic              hit;
    logic              placed;
    logic [ADDR_W-1:0] addr;
  } packet_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tracker_upd_t;

endpackage
`default_nettype wire

[src/asqf_cell.sv]
`default_nettype none
module asqf_cell (
  input  wire              clk,
  input  wire              rst,
  input  wire              advance,
  input  wire asqf_pkg::packet_t pin,
  output asqf_pkg::packet_t pout
);
  import asqf_pkg::*;

  logic [ADDR_W-1:0] entry;
  logic              used;
  logic              match;
  logic              take;
  packet_t           pout_next;

  assign match = pin.valid && used && (entry == pin.addr);
  assign take  = pin.valid && (pin.op == OP_INSERT) && !pin.hit && !pin.placed && !used;

  always_comb begin
    pout_next = pin;
    if (match) begin
      pout_next.hit = 1'b1;
    end
    if (take) begin
      pout_next.placed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      pout <= '0;
    end else if (advance) begin
      pout <= pout_next;
      if (take) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      entry <= pin.addr;
    end
  end

endmodule
`default_nettype wire

[src/asqf_filter.sv]
`default_nettype none
module asqf_filter (
  input  wire                      clk,
  input  wire                      rst,
  input  wire [63:0]               addr,
  input  wire asqf_pkg::tracker_upd_t upd,
  output logic                     pass
);
  import asqf_pkg::*;

  logic [LOW_W-1:0]  low_min;
  logic [LOW_W-1:0]  low_max;
  logic [LOW_W-1:0]  low_bits;
  logic [ADDR_W-1:0] high_min;
  logic [ADDR_W-1:0] high_max;
  logic [ADDR_W-1:0] high_bits;

  logic              q_low;
  logic [LOW_W-1:0]  q_v;
  logic              u_low;
  logic [LOW_W-1:0]  u_v;

  assign q_low = (addr[ADDR_W-1:LOW_W] == '0);
  assign q_v   = addr[LOW_W-1:0];
  assign u_low = (upd.addr[ADDR_W-1:LOW_W] == '0);
  assign u_v   = upd.addr[LOW_W-1:0];

  always_comb begin
    if (q_low) begin
      pass = !((q_v > low_max) || (q_v < low_min) || ((q_v & ~low_bits) != '0));
    end else begin
      pass = !((addr > high_max) || (addr < high_min) || ((addr & ~high_bits) != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_min   <= '1;
      low_max   <= '0;
      low_bits  <= '0;
      high_min  <= '1;
      high_max  <= '0;
      high_bits <= '0;
    end else if (upd.en) begin
      if (u_low) begin
        if (u_v > low_max) low_max <= u_v;
        if (u_v < low_min) low_min <= u_v;
        low_bits <= low_bits | u_v;
      end else begin
        if (upd.addr > high_max) high_max <= upd.addr;
        if (upd.addr < high_min) high_min <= upd.addr;
        high_bits <= high_bits | upd.addr;
      end
    end
  end

endmodule
`default_nettype wire

[src/address_set_with_quick_filter_top.sv]
// result: an insert or a lookup that passes the filter walks all CAPACITY cells before its result
// is registered; a lookup that the range and bit-mask filter rejects has its result registered directly
// throughput: one item at a time; an item walks the cell chain one cell per cycle unless
// output back-pressure holds it, and no new item is accepted until it leaves the chain
// reset: synchronous, active high; clears all entry valid bits, the trackers and the handshakes
`default_nettype none
module address_set_with_quick_filter_top #(
  parameter int CAPACITY = 64
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [71:0] s_tdata,   // operation [0], address [64:1], zero [71:65]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata    // found [0], status [2:1], zero [7:3]
);
  import asqf_pkg::*;

  packet_t           pkt [CAPACITY+1];
  packet_t           tail;
  tracker_upd_t      upd;
  logic              in_op;
  logic [ADDR_W-1:0] in_addr;
  logic              pass;
  logic              accept;
  logic              reject;
  logic              advance;
  logic              capture;
  logic [1:0]        tail_status;
  logic              busy;
  logic              res_found;
  logic [1:0]        res_status;

  assign in_op   = s_tdata[0];
  assign in_addr = s_tdata[64:1];
  assign accept  = s_tvalid && s_tready;
  assign reject  = (in_op == OP_LOOKUP) && !pass;

  assign s_tready = !busy && (!m_tvalid || m_tready);

  always_comb begin
    pkt[0].valid  = accept && !reject;
    pkt[0].op     = in_op;
    pkt[0].hit    = 1'b0;
    pkt[0].placed = 1'b0;
    pkt[0].addr   = in_addr;
  end

  assign tail    = pkt[CAPACITY];
  assign advance = !(tail.valid && m_tvalid && !m_tready);
  assign capture = tail.valid && advance;

  always_comb begin
    if (tail.op == OP_LOOKUP) begin
      tail_status = ST_DONE;
    end else if (tail.hit) begin
      tail_status = ST_DUP;
    end else if (tail.placed) begin
      tail_status = ST_DONE;
    end else begin
      tail_status = ST_FULL;
    end
  end

  assign upd.en   = capture && (tail.op == OP_INSERT) && tail.placed;
  assign upd.addr = tail.addr;

  asqf_filter u_filter (
    .clk  (clk),
    .rst  (rst),
    .addr (in_addr),
    .upd  (upd),
    .pass (pass)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    asqf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .pin     (pkt[i]),
      .pout    (pkt[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept && !reject) begin
        busy <= 1'b1;
      end else if (capture) begin
        busy <= 1'b0;
      end
      if (capture) begin
        m_tvalid   <= 1'b1;
        res_found  <= tail.hit;
        res_status <= tail_status;
      end else if (accept && reject) begin
        m_tvalid   <= 1'b1;
        res_found  <= 1'b0;
        res_status <= ST_DONE;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'b0, res_status, res_found};

endmodule
`default_nettype wire
